// File: rtl/smau_pkg.sv
// ----------------------------------------------------------------------------
// smau_pkg
// Shared types and constants for the stack machine arithmetic unit: command
// and status codes, sequencer states and the fixed word widths.
// ----------------------------------------------------------------------------
package smau_pkg;

    localparam int WORD_W  = 32;
    localparam int ADD_W   = WORD_W + 2;
    localparam int ITER_W  = 5;
    localparam int DEPTH_W = 7;

    // last iteration of the bit-serial multiply and divide loops
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(WORD_W - 1);

    typedef enum logic [2:0] {
        CMD_NOP  = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_PUSH = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_ABS_A,
        S_ABS_B,
        S_DIV_STEP,
        S_DIV_FIX,
        S_MUL_STEP,
        S_WRITE_BACK
    } t_state;

endpackage

// File: rtl/stack_machine_arith_unit_core.sv
// Sequence per command: push, nop and error cases finish in the decode state; add
// and sub go on to the write-back; mul runs 32 shift-add steps; div runs two
// magnitude steps, 32 restoring steps and a sign fix-up before the write-back.
// Throughput: one command at a time; busy is high from the cycle after start
// until the result strobe, which is also the first cycle a new start is taken.
// Reset (synchronous, active low) empties the stack; no clearing pass is run.
// ----------------------------------------------------------------------------
// stack_machine_arith_unit_core
// Operand stack of signed 32-bit words in a memory, with one shared 34-bit
// adder/subtractor driven by a small sequencer for add, sub, mul and div.
// ----------------------------------------------------------------------------
module stack_machine_arith_unit_core
    import smau_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                i_cmd,
    input  logic signed [WORD_W-1:0]  i_push_value,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic signed [WORD_W-1:0]  o_top_value,
    output logic [DEPTH_W-1:0]        o_depth
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // sequencer and operand registers
    t_state              r_state, n_state;
    logic [2:0]          r_cmd;
    logic [WORD_W-1:0]   r_pv;
    logic [CW-1:0]       r_count, n_count;
    logic [WORD_W-1:0]   r_top, n_top;
    logic [WORD_W-1:0]   r_a, n_a;
    logic [WORD_W-1:0]   r_b, n_b;
    logic [WORD_W-1:0]   r_acc, n_acc;
    logic [WORD_W-1:0]   r_res, n_res;
    logic [ITER_W-1:0]   r_iter, n_iter;
    logic                r_neg, n_neg;
    logic                r_valid, n_valid;
    t_status             r_status, n_status;

    // stack memory
    logic [WORD_W-1:0]   r_mem [STACK_DEPTH];
    logic [WORD_W-1:0]   r_rd_data;
    logic [AW-1:0]       w_rd_addr;
    logic                w_mem_we;
    logic [AW-1:0]       w_mem_waddr;
    logic [WORD_W-1:0]   w_mem_wdata;
    logic [CW-1:0]       w_cnt_m2;

    // shared adder
    logic [ADD_W-1:0]    w_add_x, w_add_y, w_sum;
    logic                w_add_sub;

    logic [CW+DEPTH_W-1:0] w_depth_ext;

    assign w_cnt_m2  = r_count - CW'(2);
    assign w_rd_addr = w_cnt_m2[AW-1:0];

    // memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // shared add/subtract unit
    assign w_sum = w_add_x + (w_add_sub ? ~w_add_y : w_add_y) + ADD_W'(w_add_sub);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_valid  <= n_valid;
            r_status <= n_status;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
            r_pv  <= i_push_value;
        end
        r_top  <= n_top;
        r_a    <= n_a;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_res  <= n_res;
        r_iter <= n_iter;
        r_neg  <= n_neg;
    end

    // next state, adder operands and memory write
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top       = r_top;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_res       = r_res;
        n_iter      = r_iter;
        n_neg       = r_neg;
        n_valid     = 1'b0;
        n_status    = r_status;
        w_add_x     = '0;
        w_add_y     = '0;
        w_add_sub   = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = w_rd_addr;
        w_mem_wdata = r_res;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end

            // decode the command; second operand is on the read port now
            S_EXEC: begin
                w_add_x   = {{2{r_rd_data[WORD_W-1]}}, r_rd_data};
                w_add_y   = {{2{r_top[WORD_W-1]}}, r_top};
                w_add_sub = (r_cmd == CMD_SUB);
                n_a       = r_rd_data;
                n_b       = r_top;
                n_acc     = '0;
                n_iter    = '0;
                n_neg     = r_rd_data[WORD_W-1] ^ r_top[WORD_W-1];
                n_status  = ST_OK;
                n_state   = S_IDLE;
                case (r_cmd)
                    CMD_PUSH: begin
                        if (r_count == CW'(STACK_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_mem_we    = 1'b1;
                            w_mem_waddr = r_count[AW-1:0];
                            w_mem_wdata = r_pv;
                            n_count     = r_count + CW'(1);
                            n_top       = r_pv;
                        end
                        n_valid = 1'b1;
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                        if (r_count < CW'(2)) begin
                            n_status = ST_SHORT;
                            n_valid  = 1'b1;
                        end else if (r_cmd == CMD_MUL) begin
                            n_state = S_MUL_STEP;
                        end else if (r_cmd == CMD_DIV) begin
                            if (r_top == '0) begin
                                n_status = ST_DIVZERO;
                                n_valid  = 1'b1;
                            end else begin
                                n_state = S_ABS_A;
                            end
                        end else begin
                            n_res   = w_sum[WORD_W-1:0];
                            n_state = S_WRITE_BACK;
                        end
                    end
                    default: begin
                        n_valid = 1'b1;
                    end
                endcase
            end

            // magnitudes of dividend and divisor
            S_ABS_A: begin
                w_add_y   = {2'b00, r_a};
                w_add_sub = 1'b1;
                if (r_a[WORD_W-1]) begin
                    n_a = w_sum[WORD_W-1:0];
                end
                n_state = S_ABS_B;
            end

            S_ABS_B: begin
                w_add_y   = {2'b00, r_b};
                w_add_sub = 1'b1;
                if (r_b[WORD_W-1]) begin
                    n_b = w_sum[WORD_W-1:0];
                end
                n_state = S_DIV_STEP;
            end

            // restoring division, quotient bits shift into r_a
            S_DIV_STEP: begin
                w_add_x   = {1'b0, r_acc, r_a[WORD_W-1]};
                w_add_y   = {2'b00, r_b};
                w_add_sub = 1'b1;
                if (!w_sum[ADD_W-1]) begin
                    n_acc = w_sum[WORD_W-1:0];
                end else begin
                    n_acc = {r_acc[WORD_W-2:0], r_a[WORD_W-1]};
                end
                n_a    = {r_a[WORD_W-2:0], ~w_sum[ADD_W-1]};
                n_iter = r_iter + ITER_W'(1);
                if (r_iter == ITER_LAST) begin
                    n_state = S_DIV_FIX;
                end
            end

            // apply quotient sign
            S_DIV_FIX: begin
                w_add_y   = {2'b00, r_a};
                w_add_sub = 1'b1;
                n_res     = r_neg ? w_sum[WORD_W-1:0] : r_a;
                n_state   = S_WRITE_BACK;
            end

            // shift-add multiply, low word only
            S_MUL_STEP: begin
                w_add_x = {2'b00, r_acc};
                w_add_y = {2'b00, r_a};
                if (r_b[0]) begin
                    n_acc = w_sum[WORD_W-1:0];
                end
                n_a    = {r_a[WORD_W-2:0], 1'b0};
                n_b    = {1'b0, r_b[WORD_W-1:1]};
                n_iter = r_iter + ITER_W'(1);
                if (r_iter == ITER_LAST) begin
                    n_res   = r_b[0] ? w_sum[WORD_W-1:0] : r_acc;
                    n_state = S_WRITE_BACK;
                end
            end

            // result replaces the second element, stack shrinks by one
            S_WRITE_BACK: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = w_rd_addr;
                w_mem_wdata = r_res;
                n_count     = r_count - CW'(1);
                n_top       = r_res;
                n_valid     = 1'b1;
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_top_value = (r_count == '0) ? '0 : r_top;
    assign w_depth_ext = {{DEPTH_W{1'b0}}, r_count};
    assign o_depth     = w_depth_ext[DEPTH_W-1:0];

endmodule

// File: rtl/smau_checker.sv
// ----------------------------------------------------------------------------
// smau_checker
// Port-level checks for the stack machine arithmetic unit, bound to the core.
// ----------------------------------------------------------------------------
module smau_checker
    import smau_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      o_valid,
    input logic [1:0]                o_status,
    input logic signed [WORD_W-1:0]  o_top_value,
    input logic [DEPTH_W-1:0]        o_depth
);

    // an accepted transfer makes the unit busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // result strobe lasts one cycle and only once the unit is free
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && !$past(o_valid)))
        else $error("result strobe while busy or held over two cycles");

    // at a result strobe, an empty stack shows zero on top
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_depth == '0) |-> (o_top_value == '0))
        else $error("empty stack with non-zero top value");

    // too-short status only with fewer than two elements
    a_short_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SHORT) |-> (o_depth < DEPTH_W'(2)))
        else $error("too-short status with two or more elements");

endmodule

bind stack_machine_arith_unit_core smau_checker u_smau_checker (.*);
